// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] RESET_COLOR = 8'h07;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] code;
    } cell_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_character_writer.sv =====
// Text console character writer: a teletype engine over a ROWS x COLUMNS cell store.
// Input channel (in_valid / in_stall) carries one command per transfer: put a
// character (newline, tab, return and backspace interpreted), read one cell, or
// clear the screen and home the cursor. Every input transfer gives exactly one
// output transfer (out_valid / out_stall) with the cursor after the command, the
// read cell and a flag for scrolling. blank_reg is written through cfg_write_en.
// After S_IDLE a command passes S_EXEC and S_DONE; an in-range read also passes S_READ,
// a tab stays in S_EXEC for each extra space, and a scroll or a clear passes S_SWEEP.
// Scrolling moves a top-row pointer and blanks one row, one cell a cycle through the
// single write port of the cell memory; clear writes every cell.
// A new command is taken as soon as the previous result sits in the output
// register; if that result is still stalled, the next one waits in the engine.
// After reset the engine writes a space in colour 7 to every cell, one per cycle
// (2000 cells at the default size) with in_stall held high; configuration writes
// are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module text_console_character_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [7:0] cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] char_code,
    input  wire logic [7:0] char_color,
    input  wire logic [4:0] read_row,
    input  wire logic [6:0] read_col,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [4:0]      cursor_row,
    output logic [6:0]      cursor_col,
    output logic [7:0]      cell_char,
    output logic [7:0]      cell_color,
    output logic            scrolled
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_X    = (COL_W + 1)'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SWEEP,
        S_DONE
    } state_t;

    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, top};
        if (s >= ROWS_X)
        begin
            s = s - ROWS_X;
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * COLS_A + ADDR_W'(col);
    endfunction

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [7:0]          char_reg, char_next;
    logic [7:0]          color_reg, color_next;
    logic [4:0]          rrow_reg, rrow_next;
    logic [6:0]          rcol_reg, rcol_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    tcw_pkg::cell_t      fill_reg, fill_next;
    logic                scroll_reg, scroll_next;
    tcw_pkg::cell_t      cell_reg, cell_next;
    logic                out_valid_reg, out_valid_next;
    logic [4:0]          out_row_reg, out_row_next;
    logic [6:0]          out_col_reg, out_col_next;
    tcw_pkg::cell_t      out_cell_reg, out_cell_next;
    logic                out_scroll_reg, out_scroll_next;
    logic [7:0]          blank_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    tcw_pkg::cell_t      ram_wdata;
    logic [15:0]         ram_rdata;

    logic [COL_W:0]      col_inc;
    logic [COL_W-1:0]    col_dec;
    logic                wrap;
    logic                last_row;
    logic [ROW_W-1:0]    cur_prow;
    logic [ROW_W-1:0]    top_inc;
    logic                read_ok;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_reg <= tcw_pkg::RESET_COLOR;
        end
        else if (cfg_write_en)
        begin
            blank_reg <= cfg_write_data;
        end
    end

    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign col_dec  = col_reg - 1'b1;
    assign wrap     = (col_inc == COLS_X);
    assign last_row = (row_reg == LAST_ROW);
    assign cur_prow = phys_row(row_reg, top_reg);
    assign top_inc  = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
    assign read_ok  = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        char_next       = char_reg;
        color_next      = color_reg;
        rrow_next       = rrow_reg;
        rcol_next       = rcol_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        top_next        = top_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        fill_next       = fill_reg;
        scroll_next     = scroll_reg;
        cell_next       = cell_reg;
        out_valid_next  = out_valid_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_cell_next   = out_cell_reg;
        out_scroll_next = out_scroll_reg;
        ram_we          = 1'b0;
        ram_waddr       = cell_addr(cur_prow, col_reg);
        ram_wdata       = '{color: color_reg, code: char_reg};
        ram_raddr       = cell_addr(phys_row(ROW_W'(rrow_reg), top_reg), COL_W'(rcol_reg));

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = '{color: tcw_pkg::RESET_COLOR, code: tcw_pkg::CH_SPACE};
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = operation;
                    char_next   = char_code;
                    color_next  = char_color;
                    rrow_next   = read_row;
                    rcol_next   = read_col;
                    scroll_next = 1'b0;
                    cell_next   = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    tcw_pkg::OP_PUT:
                    begin
                        if (char_reg == tcw_pkg::CH_RETURN)
                        begin
                            col_next   = '0;
                            state_next = S_DONE;
                        end
                        else if (char_reg == tcw_pkg::CH_BACKSPACE)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next  = col_dec;
                                ram_we    = 1'b1;
                                ram_waddr = cell_addr(cur_prow, col_dec);
                                ram_wdata = '{color: color_reg, code: tcw_pkg::CH_SPACE};
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (char_reg != tcw_pkg::CH_NEWLINE)
                            begin
                                ram_we = 1'b1;
                                if (char_reg == tcw_pkg::CH_TAB)
                                begin
                                    ram_wdata = '{color: color_reg, code: tcw_pkg::CH_SPACE};
                                end
                            end
                            if (char_reg == tcw_pkg::CH_NEWLINE || wrap)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    // blank the old top row, which becomes the bottom
                                    addr_next   = cell_addr(top_reg, '0);
                                    end_next    = cell_addr(top_reg, '0) + (COLS_A - 1'b1);
                                    fill_next   = '{color: blank_reg, code: tcw_pkg::CH_SPACE};
                                    top_next    = top_inc;
                                    scroll_next = 1'b1;
                                    state_next  = S_SWEEP;
                                end
                                else
                                begin
                                    row_next   = row_reg + 1'b1;
                                    state_next = S_DONE;
                                end
                            end
                            else
                            begin
                                col_next = col_inc[COL_W-1:0];
                                if (char_reg != tcw_pkg::CH_TAB || col_inc[1:0] == 2'd0)
                                begin
                                    state_next = S_DONE;
                                end
                            end
                        end
                    end
                    tcw_pkg::OP_READ:
                    begin
                        state_next = read_ok ? S_READ : S_DONE;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        top_next   = '0;
                        addr_next  = '0;
                        end_next   = LAST_ADDR;
                        fill_next  = '{color: blank_reg, code: tcw_pkg::CH_SPACE};
                        state_next = S_SWEEP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cell_next  = tcw_pkg::cell_t'(ram_rdata);
                state_next = S_DONE;
            end
            S_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = fill_reg;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == end_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = 5'(row_reg);
                    out_col_next    = 7'(col_reg);
                    out_cell_next   = cell_reg;
                    out_scroll_next = scroll_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            op_reg         <= tcw_pkg::OP_PUT;
            char_reg       <= '0;
            color_reg      <= '0;
            rrow_reg       <= '0;
            rcol_reg       <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            top_reg        <= '0;
            addr_reg       <= '0;
            end_reg        <= '0;
            fill_reg       <= '0;
            scroll_reg     <= 1'b0;
            cell_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_cell_reg   <= '0;
            out_scroll_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            char_reg       <= char_next;
            color_reg      <= color_next;
            rrow_reg       <= rrow_next;
            rcol_reg       <= rcol_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            top_reg        <= top_next;
            addr_reg       <= addr_next;
            end_reg        <= end_next;
            fill_reg       <= fill_next;
            scroll_reg     <= scroll_next;
            cell_reg       <= cell_next;
            out_valid_reg  <= out_valid_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_cell_reg   <= out_cell_next;
            out_scroll_reg <= out_scroll_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cursor_row = out_row_reg;
    assign cursor_col = out_col_reg;
    assign cell_char  = out_cell_reg.code;
    assign cell_color = out_cell_reg.color;
    assign scrolled   = out_scroll_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS = 25
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [4:0] cursor_row,
    input wire logic [6:0] cursor_col,
    input wire logic [7:0] cell_char,
    input wire logic [7:0] cell_color,
    input wire logic       scrolled
);

    logic [1:0] pend_reg, pend_next;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_row) && $stable(cursor_col))
        else $error("result dropped or changed while stalled");

    // no result without a pending command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a command");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_col) < COLUMNS)
        else $error("cursor column out of range");

    // a scroll leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_row == 5'(ROWS - 1))
        else $error("scroll without cursor on bottom row");

    a_read_no_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cell_char != 8'd0 || cell_color != 8'd0) |-> !scrolled)
        else $error("cell data with scroll flag");

endmodule

bind text_console_character_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire
